// ----- rtl/mcr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_pkg
// shared widths, constants and control types of the midpoint circle rasterizer
// ----------------------------------------------------------------------------
package mcr_pkg;

    localparam int CoordW   = 8;
    localparam int RadiusW  = 3;
    localparam int ColorW   = 24;
    localparam int PixW     = 10;
    localparam int OffW     = 4;   // offsets with headroom for one increment
    localparam int ErrW     = 8;
    localparam int OctW     = 3;
    localparam int IterW    = 3;
    localparam int InDataW  = 48;  // 43 payload bits padded to bytes
    localparam int OutDataW = 48;  // 44 payload bits padded to bytes

    localparam logic [RadiusW-1:0] MAX_RADIUS = 3'd7;
    // 48 pixels at most, eight per step
    localparam logic [IterW-1:0]   MAX_ITERS  = 3'd6;
    localparam logic [OctW-1:0]    OCT_LAST   = 3'd7;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;  // latch a new request
        logic emit;  // register current pixel and advance
    } cmd_t;

    typedef struct packed {
        logic last;  // current pixel closes the circle
    } stat_t;

endpackage

// ----- rtl/mcr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_ctrl
// request/emit sequencer and output valid flag
// ----------------------------------------------------------------------------
module mcr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output mcr_pkg::cmd_t cmd,
    input  mcr_pkg::stat_t stat
);
    import mcr_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd.load     = 1'b0;
        cmd.emit     = 1'b0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // output slot free or being drained this cycle
                cmd.emit = !m_valid_reg || m_tready;
                if (cmd.emit) begin
                    m_valid_next = 1'b1;
                    if (stat.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// ----- rtl/mcr_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_dpath
// midpoint offsets, decision error, octant mirror and output register
// ----------------------------------------------------------------------------
module mcr_dpath (
    input  logic                            aclk,
    input  logic [mcr_pkg::CoordW-1:0]      center_x,
    input  logic [mcr_pkg::CoordW-1:0]      center_y,
    input  logic [mcr_pkg::RadiusW-1:0]     radius,
    input  logic [mcr_pkg::ColorW-1:0]      pixel_color,
    input  mcr_pkg::cmd_t                   cmd,
    output mcr_pkg::stat_t                  stat,
    output logic signed [mcr_pkg::PixW-1:0] pixel_x,
    output logic signed [mcr_pkg::PixW-1:0] pixel_y,
    output logic [mcr_pkg::ColorW-1:0]      out_color,
    output logic                            last_pixel
);
    import mcr_pkg::*;

    logic [CoordW-1:0]      cx_reg, cy_reg;
    logic [ColorW-1:0]      color_reg;
    logic [OffW-1:0]        a_reg, a_next;
    logic [OffW-1:0]        b_reg, b_next;
    logic signed [ErrW-1:0] err_reg, err_next;
    logic [OctW-1:0]        oct_reg;
    logic [IterW-1:0]       iter_reg, iter_next;
    logic                   zero_reg;

    logic signed [PixW-1:0] px_reg, py_reg;
    logic [ColorW-1:0]      pcolor_reg;
    logic                   plast_reg;

    logic [RadiusW-1:0]     r_sat;
    logic signed [ErrW-1:0] diff;
    logic                   stop_next;
    logic [OffW-1:0]        off_x, off_y;
    logic                   neg_x, neg_y;
    logic signed [PixW-1:0] cur_x, cur_y;

    assign r_sat = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;

    // midpoint step, applied after the eighth octant pixel
    always_comb begin
        b_next    = b_reg + OffW'(1);
        a_next    = a_reg;
        iter_next = iter_reg + IterW'(1);
        diff      = '0;
        if (err_reg < 0) begin
            err_next = err_reg + signed'({{(ErrW-OffW-1){1'b0}}, b_next, 1'b1});
        end else begin
            a_next   = a_reg - OffW'(1);
            diff     = signed'(ErrW'(b_next)) - signed'(ErrW'(a_next)) + ErrW'(1);
            err_next = err_reg + (diff <<< 1);
        end
        stop_next = (a_next < b_next) || (iter_next == MAX_ITERS);
    end

    // octant mirror: odd octants swap a and b
    always_comb begin
        off_x = oct_reg[0] ? b_reg : a_reg;
        off_y = oct_reg[0] ? a_reg : b_reg;
        neg_x = oct_reg[2] ^ oct_reg[1];
        neg_y = oct_reg[2];
        cur_x = neg_x ? signed'(PixW'(cx_reg)) - signed'(PixW'(off_x))
                      : signed'(PixW'(cx_reg)) + signed'(PixW'(off_x));
        cur_y = neg_y ? signed'(PixW'(cy_reg)) - signed'(PixW'(off_y))
                      : signed'(PixW'(cy_reg)) + signed'(PixW'(off_y));
    end

    assign stat.last = zero_reg || ((oct_reg == OCT_LAST) && stop_next);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg    <= center_x;
            cy_reg    <= center_y;
            color_reg <= pixel_color;
            a_reg     <= OffW'(r_sat);
            b_reg     <= '0;
            err_reg   <= ErrW'(1) - signed'(ErrW'(r_sat));
            oct_reg   <= '0;
            iter_reg  <= '0;
            zero_reg  <= (r_sat == '0);
        end else if (cmd.emit) begin
            oct_reg <= oct_reg + OctW'(1);
            if (oct_reg == OCT_LAST) begin
                a_reg    <= a_next;
                b_reg    <= b_next;
                err_reg  <= err_next;
                iter_reg <= iter_next;
            end
        end
        if (cmd.emit) begin
            px_reg     <= cur_x;
            py_reg     <= cur_y;
            pcolor_reg <= color_reg;
            plast_reg  <= stat.last;
        end
    end

    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign out_color  = pcolor_reg;
    assign last_pixel = plast_reg;

endmodule

// ----- rtl/midpoint_circle_rasterizer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit
// outline pixels of a circle by the integer midpoint method
// ----------------------------------------------------------------------------
// usage:
//  - slave channel takes one circle request per transfer: center, radius, color
//  - master channel gives one pixel per transfer, signed and unclipped;
//    m_tlast marks the final pixel of a circle
//  - radius zero gives the center pixel alone; above the maximum radius the
//    radius saturates
//  - each midpoint step yields eight mirrored pixels in fixed order,
//    duplicates kept; a radius of seven gives 48 pixels
//  - the request is latched into the walk registers; each pixel, the first
//    too, is then registered in the output register before m_tvalid shows it
//  - throughput: one pixel per cycle from the emit sequencer while the receiver keeps up
//  - s_tready is high only while no circle is being walked; the next request
//    may be taken while the last pixel still waits in the output register
//  - a stalled receiver holds the output register and freezes the walk
//  - reset (aresetn low, synchronous) returns to idle and drops m_tvalid
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // center_x[7:0], center_y[15:8], radius[18:16], pixel_color[42:19], zero pad
    input  logic [mcr_pkg::InDataW-1:0]     s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pixel_x[9:0], pixel_y[19:10], out_color[43:20], zero pad
    output logic [mcr_pkg::OutDataW-1:0]    m_tdata,
    output logic                            m_tlast,  // last_pixel
    output logic                            m_tvalid,
    input  logic                            m_tready
);
    import mcr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    logic signed [PixW-1:0] pixel_x, pixel_y;
    logic [ColorW-1:0]      out_color;

    // sequencer: request hand-off, emit pacing, output valid
    mcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // offsets, decision error and the pixel output register
    mcr_dpath u_dpath (
        .aclk        (aclk),
        .center_x    (s_tdata[7:0]),
        .center_y    (s_tdata[15:8]),
        .radius      (s_tdata[18:16]),
        .pixel_color (s_tdata[42:19]),
        .cmd         (cmd),
        .stat        (stat),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .out_color   (out_color),
        .last_pixel  (m_tlast)
    );

    // pack result fields, lowest first, pad to whole bytes
    assign m_tdata = {4'b0000, out_color, pixel_y, pixel_x};

endmodule

// ----- rtl/mcr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcr_checker
// port-level checks of the midpoint circle rasterizer
// ----------------------------------------------------------------------------
module mcr_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [mcr_pkg::OutDataW-1:0] m_tdata,
    input logic                         m_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready
);
    import mcr_pkg::*;

    // stalled transfer keeps valid
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // stalled transfer keeps its payload
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("pixel changed while stalled");

    // a taken request starts a walk, so no second request the next cycle
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while circle in progress");

    // a non-final pixel on the output means the circle is still in progress
    a_busy_mid_circle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("ready raised before last pixel");

endmodule

bind midpoint_circle_rasterizer_unit mcr_checker u_mcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
